[sv/cpt_pkg.sv]
// Shared definitions for the closest-point-on-triangle pipeline.
// Holds the default coordinate width, the multiplier slice width and the region codes.
package cpt_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MUL_CHUNK       = 32;

  typedef enum logic [2:0] {
    REGION_A   = 3'd0,
    REGION_B   = 3'd1,
    REGION_C   = 3'd2,
    REGION_AB  = 3'd3,
    REGION_AC  = 3'd4,
    REGION_BC  = 3'd5,
    REGION_INT = 3'd6
  } region_t;

endpackage

[sv/closest_point_on_triangle_unit.sv]
// Closest point on a triangle to a query point; streaming top level.
// Depends on cpt_pkg, cpt_pipe, cpt_mul and cpt_div.
//
// Takes one query word per cycle while the result side is not stalled, and returns one
// result word per query, in order. The pipeline ends in the three dividers, which
// resolve one quotient bit per stage over COORD_WIDTH+2 stages, after nine stages of
// differences, dot products, minors, region selection and numerators.
// A stall on the result side holds every stage; in_tready drops only while a result
// is waiting and out_tready is low.
module closest_point_on_triangle_unit #(
  parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // q_x, q_y, q_z, region
  output logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] out_tdata
);
  import cpt_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int E      = W + 1;
  localparam int P      = 2 * E;
  localparam int D      = P + 2;
  localparam int V      = 2 * D + 1;
  localparam int NW     = E + V + 1;
  localparam int DW     = V + 2;
  localparam int Q      = W + 2;
  localparam int LAT    = Q + 11;
  localparam int OUT_TW = ((3*W+3+7)/8)*8;
  localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

  function automatic logic [E-1:0] sub_e(input logic [W-1:0] x, input logic [W-1:0] y);
    return E'($signed(x)) - E'($signed(y));
  endfunction

  function automatic logic [P-1:0] mul_e(input logic [E-1:0] x, input logic [E-1:0] y);
    return P'($signed(x)) * P'($signed(y));
  endfunction

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // stage 1: edge and offset vectors
  logic [2:0][W-1:0] p_in, a_in, b_in, c_in;
  logic [2:0][W-1:0] a1_r, b1_r, c1_r;
  logic [2:0][E-1:0] ab1_r, ac1_r, bc1_r, ap1_r, bp1_r, cp1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_in[k] = in_tdata[k*W +: W];
      a_in[k] = in_tdata[(3+k)*W +: W];
      b_in[k] = in_tdata[(6+k)*W +: W];
      c_in[k] = in_tdata[(9+k)*W +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a1_r[k]  <= a_in[k];
        b1_r[k]  <= b_in[k];
        c1_r[k]  <= c_in[k];
        ab1_r[k] <= sub_e(b_in[k], a_in[k]);
        ac1_r[k] <= sub_e(c_in[k], a_in[k]);
        bc1_r[k] <= sub_e(c_in[k], b_in[k]);
        ap1_r[k] <= sub_e(p_in[k], a_in[k]);
        bp1_r[k] <= sub_e(p_in[k], b_in[k]);
        cp1_r[k] <= sub_e(p_in[k], c_in[k]);
      end
    end
  end

  // stage 2: coordinate products
  logic [5:0][2:0][P-1:0] pr2_r;
  logic [2:0][W-1:0]      a2_r, b2_r, c2_r;
  logic [2:0][E-1:0]      ab2_r, ac2_r, bc2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      c2_r  <= c1_r;
      ab2_r <= ab1_r;
      ac2_r <= ac1_r;
      bc2_r <= bc1_r;
      for (int k = 0; k < 3; k++) begin
        pr2_r[0][k] <= mul_e(ab1_r[k], ap1_r[k]);
        pr2_r[1][k] <= mul_e(ac1_r[k], ap1_r[k]);
        pr2_r[2][k] <= mul_e(ab1_r[k], bp1_r[k]);
        pr2_r[3][k] <= mul_e(ac1_r[k], bp1_r[k]);
        pr2_r[4][k] <= mul_e(ab1_r[k], cp1_r[k]);
        pr2_r[5][k] <= mul_e(ac1_r[k], cp1_r[k]);
      end
    end
  end

  // stage 3: dot products d1..d6
  typedef struct packed {
    logic [5:0][D-1:0] d;
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [2:0][W-1:0] c;
    logic [2:0][E-1:0] ab;
    logic [2:0][E-1:0] ac;
    logic [2:0][E-1:0] bc;
  } car1_t;

  car1_t car3_r, car5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        car3_r.d[j] <= D'($signed(pr2_r[j][0])) + D'($signed(pr2_r[j][1]))
                     + D'($signed(pr2_r[j][2]));
      end
      car3_r.a  <= a2_r;
      car3_r.b  <= b2_r;
      car3_r.c  <= c2_r;
      car3_r.ab <= ab2_r;
      car3_r.ac <= ac2_r;
      car3_r.bc <= bc2_r;
    end
  end

  // stages 4-5: minor products
  logic [5:0][2*D-1:0] mv;

  for (genvar g = 0; g < 6; g++) begin : g_mv
    cpt_mul #(.AW(D), .BW(D)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (car3_r.d[MA[g]]),
      .b   (car3_r.d[MB[g]]),
      .p   (mv[g])
    );
  end

  cpt_pipe #(.WD($bits(car1_t)), .DEPTH(2)) u_car1 (
    .clk  (clk),
    .en   (en),
    .din  (car3_r),
    .dout (car5)
  );

  // stage 6: region select
  logic signed [D-1:0]  dd [6];
  logic signed [V-1:0]  vaf, vbf, vcf;
  logic signed [D:0]    e43, e56;
  logic                 ra, rb, rab, rc, rac, rbc;
  region_t              rg_nxt, rg6_r;
  logic [2:0][W-1:0]    base_nxt, base6_r;
  logic [2:0][E-1:0]    e1_nxt, e2_nxt, e16_r, e26_r;
  logic [V-1:0]         n1_nxt, n2_nxt, n16_r, n26_r;
  logic [DW-1:0]        den_nxt, den6_r;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dd[j] = $signed(car5.d[j]);
    end
    vcf = V'($signed(mv[0])) - V'($signed(mv[1]));
    vbf = V'($signed(mv[2])) - V'($signed(mv[3]));
    vaf = V'($signed(mv[4])) - V'($signed(mv[5]));
    e43 = (D+1)'(dd[3]) - (D+1)'(dd[2]);
    e56 = (D+1)'(dd[4]) - (D+1)'(dd[5]);
    ra  = (dd[0] <= 0) && (dd[1] <= 0);
    rb  = (dd[2] >= 0) && (e43 <= 0);
    rab = (vcf <= 0) && (dd[0] >= 0) && (dd[2] <= 0);
    rc  = (dd[5] >= 0) && (e56 <= 0);
    rac = (vbf <= 0) && (dd[1] >= 0) && (dd[5] <= 0);
    rbc = (vaf <= 0) && (e43 >= 0) && (e56 >= 0);

    rg_nxt   = REGION_INT;
    base_nxt = car5.a;
    e1_nxt   = car5.ab;
    e2_nxt   = car5.ac;
    n1_nxt   = vbf;
    n2_nxt   = vcf;
    den_nxt  = DW'(vaf) + DW'(vbf) + DW'(vcf);
    priority if (ra) begin
      rg_nxt  = REGION_A;
      den_nxt = '0;
    end else if (rb) begin
      rg_nxt   = REGION_B;
      base_nxt = car5.b;
      den_nxt  = '0;
    end else if (rab) begin
      rg_nxt  = REGION_AB;
      e2_nxt  = '0;
      n1_nxt  = V'(dd[0]);
      n2_nxt  = '0;
      den_nxt = DW'(dd[0]) - DW'(dd[2]);
    end else if (rc) begin
      rg_nxt   = REGION_C;
      base_nxt = car5.c;
      den_nxt  = '0;
    end else if (rac) begin
      rg_nxt  = REGION_AC;
      e1_nxt  = car5.ac;
      e2_nxt  = '0;
      n1_nxt  = V'(dd[1]);
      n2_nxt  = '0;
      den_nxt = DW'(dd[1]) - DW'(dd[5]);
    end else if (rbc) begin
      rg_nxt   = REGION_BC;
      base_nxt = car5.b;
      e1_nxt   = car5.bc;
      e2_nxt   = '0;
      n1_nxt   = V'(e43);
      n2_nxt   = '0;
      den_nxt  = DW'(e43) + DW'(e56);
    end else begin
      rg_nxt = REGION_INT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rg6_r   <= rg_nxt;
      base6_r <= base_nxt;
      e16_r   <= e1_nxt;
      e26_r   <= e2_nxt;
      n16_r   <= n1_nxt;
      n26_r   <= n2_nxt;
      den6_r  <= den_nxt;
    end
  end

  // stages 7-8: numerator products
  typedef struct packed {
    region_t           rg;
    logic [2:0][W-1:0] base;
    logic [DW-1:0]     den;
  } car2_t;

  car2_t               car6, car8;
  logic [2:0][E+V-1:0] m1, m2;

  assign car6.rg   = rg6_r;
  assign car6.base = base6_r;
  assign car6.den  = den6_r;

  for (genvar k = 0; k < 3; k++) begin : g_nm
    cpt_mul #(.AW(E), .BW(V)) u_mul1 (
      .clk (clk),
      .en  (en),
      .a   (e16_r[k]),
      .b   (n16_r),
      .p   (m1[k])
    );
    cpt_mul #(.AW(E), .BW(V)) u_mul2 (
      .clk (clk),
      .en  (en),
      .a   (e26_r[k]),
      .b   (n26_r),
      .p   (m2[k])
    );
  end

  cpt_pipe #(.WD($bits(car2_t)), .DEPTH(2)) u_car2 (
    .clk  (clk),
    .en   (en),
    .din  (car6),
    .dout (car8)
  );

  // stage 9: numerator sum
  logic [2:0][NW-1:0] num9_r;
  logic [2:0][W-1:0]  base9_r;
  logic [DW-1:0]      den9_r;
  logic [2:0]         rg9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num9_r[k] <= NW'($signed(m1[k])) + NW'($signed(m2[k]));
      end
      base9_r <= car8.base;
      den9_r  <= car8.den;
      rg9_r   <= car8.rg;
    end
  end

  // divide, add base, saturate
  logic [2:0][W-1:0] qo;
  logic [2:0]        rg_out;

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div #(.W(W), .NW(NW), .DW(DW)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (num9_r[k]),
      .den  (den9_r),
      .base (base9_r[k]),
      .q    (qo[k])
    );
  end

  cpt_pipe #(.WD(3), .DEPTH(Q+2)) u_rg (
    .clk  (clk),
    .en   (en),
    .din  (rg9_r),
    .dout (rg_out)
  );

  assign out_tdata = OUT_TW'({rg_out, qo[2], qo[1], qo[0]});

endmodule

[sv/cpt_pipe.sv]
// Delay line with a common advance enable, used to carry data beside the arithmetic.
// No dependencies.
module cpt_pipe #(
  parameter int WD    = 1,
  parameter int DEPTH = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WD-1:0] din,
  output logic [WD-1:0] dout
);

  logic [WD-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign dout = sh_r[DEPTH-1];

endmodule

[sv/cpt_mul.sv]
// Two-stage signed multiplier: slice products of b, then a shifted sum.
// Depends on cpt_pkg for the slice width.
module cpt_mul #(
  parameter int AW = 17,
  parameter int BW = 36
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import cpt_pkg::*;

  localparam int CH  = MUL_CHUNK;
  localparam int NCH = (BW + CH - 1) / CH;
  localparam int BX  = NCH * CH;
  localparam int PW  = AW + CH + 1;
  localparam int SW  = AW + BX + 1;

  logic signed [BX-1:0]    bx;
  logic signed [PW-1:0]    opa;
  logic signed [PW-1:0]    pp_r [NCH];
  logic signed [AW+BW-1:0] p_r;
  logic signed [AW+BW-1:0] p_nxt;

  assign bx  = BX'(b);
  assign opa = PW'(a);

  for (genvar i = 0; i < NCH; i++) begin : g_pp
    logic signed [PW-1:0] opb;
    if (i == NCH - 1) begin : g_top
      assign opb = PW'($signed(bx[i*CH +: CH]));
    end else begin : g_low
      assign opb = $signed(PW'(bx[i*CH +: CH]));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pp_r[i] <= opa * opb;
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    acc = '0;
    for (int i = 0; i < NCH; i++) begin
      acc = acc + (SW'(pp_r[i]) <<< (i * CH));
    end
    p_nxt = acc[AW+BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

[sv/cpt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with base add and saturation.
// No dependencies.
module cpt_div #(
  parameter int W  = 16,
  parameter int NW = 91,
  parameter int DW = 75
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic signed [W-1:0]  base,
  output logic signed [W-1:0]  q
);

  localparam int Q  = W + 2;
  localparam int RW = (NW > DW + Q) ? NW : DW + Q;
  localparam logic signed [W-1:0] HI = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] LO = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] dv;
    logic [Q-1:0]  quo;
    logic          neg;
    logic          ovf;
    logic          denz;
    logic [W-1:0]  base;
  } dstage_t;

  dstage_t st_r [Q+1];

  logic [NW-1:0] an;
  logic [DW-1:0] ad;

  assign an = num[NW-1] ? NW'(-num) : NW'(num);
  assign ad = den[DW-1] ? DW'(-den) : DW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem  <= RW'(an);
      st_r[0].dv   <= ad;
      st_r[0].quo  <= '0;
      st_r[0].neg  <= num[NW-1] ^ den[DW-1];
      st_r[0].ovf  <= 1'b0;
      st_r[0].denz <= (den == '0);
      st_r[0].base <= base;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_stage
    localparam int SH = Q - 1 - k;
    logic [RW-1:0] sub;
    logic          take;
    dstage_t       st_nxt;
    assign sub  = RW'(st_r[k].dv) << SH;
    assign take = st_r[k].rem >= sub;
    always_comb begin
      st_nxt = st_r[k];
      if (take) begin
        st_nxt.rem     = st_r[k].rem - sub;
        st_nxt.quo[SH] = 1'b1;
      end
      if (k == 0) begin
        st_nxt.ovf = (st_r[k].rem >> Q) >= RW'(st_r[k].dv);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= st_nxt;
      end
    end
  end

  logic signed [W-1:0] q_r;
  logic signed [W-1:0] q_nxt;

  always_comb begin
    logic signed [Q+1:0] qs;
    logic signed [Q+1:0] sum;
    qs = $signed({2'b00, st_r[Q].quo});
    if (st_r[Q].neg) begin
      qs = -qs;
    end
    sum = (Q+2)'($signed(st_r[Q].base)) + qs;
    priority if (st_r[Q].denz) begin
      q_nxt = st_r[Q].base;
    end else if (st_r[Q].ovf) begin
      q_nxt = st_r[Q].neg ? LO : HI;
    end else if (sum > (Q+2)'(HI)) begin
      q_nxt = HI;
    end else if (sum < (Q+2)'(LO)) begin
      q_nxt = LO;
    end else begin
      q_nxt = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[sv/cpt_checker.sv]
// Port-level checks for closest_point_on_triangle_unit, attached by bind.
// Depends on cpt_pkg for the region codes.
module cpt_checker #(
  parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] out_tdata
);
  import cpt_pkg::*;

  localparam int RL = 3 * COORD_WIDTH;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stall");

  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[RL +: 3] <= REGION_INT)
    else $error("region code out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind closest_point_on_triangle_unit cpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_checker (.*);
